### hw/rtl/wav_pkg.sv
// Shared types and constants for the weighted action vote block.
package wav_pkg;

    // Width of an action index and the most bins an action index can reach.
    localparam int ACT_W     = 4;
    localparam int ACT_LIMIT = 1 << ACT_W;

    // Width of the action count register, weight and bin totals.
    localparam int CNT_W    = 5;
    localparam int WEIGHT_W = 16;
    localparam int BIN_W    = 32;

    // Action count after reset.
    localparam logic [CNT_W-1:0] NUM_ACTIONS_RST = CNT_W'(ACT_LIMIT);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } wav_state_t;

    // Control bundle from the sequencer to the bin memory.
    typedef struct packed {
        logic             rd_en;
        logic [ACT_W-1:0] rd_addr;
        logic             wr_en;
        logic [ACT_W-1:0] wr_addr;
        logic [BIN_W-1:0] wr_data;
        logic             clr;
    } wav_mem_ctl_t;

endpackage

### hw/rtl/wav_bin_mem.sv
// Bin memory: one read and one write port, registered read, per-bin valid bits.
module wav_bin_mem
    import wav_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wav_mem_ctl_t     ctl,
    output logic [BIN_W-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BIN_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [BIN_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    wr_idx;

    // Writes and scan reads stay within the bins in use, so the upper bits can be dropped.
    assign rd_idx = ctl.rd_addr[AW-1:0];
    assign wr_idx = ctl.wr_addr[AW-1:0];

    // Storage array, written without reset.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= ctl.wr_data;
        end
    end

    // Valid bits: a bin that is not valid reads as zero, so a clear resets only these bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/weighted_action_vote_top.sv
// Weighted action vote: per-action weight bins with an argmax on the last vote.
//
// Input channel (in_valid, in_stall): one transaction carries one vote, namely
// vote_action, vote_weight (unsigned Q0.16) and last_vote. Output channel
// (out_valid, out_stall): one transaction carries best_action and is produced
// only for a vote flagged last_vote.
// A vote is a read of its bin, then the saturating add and the write back
// through the single adder; a further vote is accepted only once the sequencer
// is idle again. For a last vote the same adder then compares the bins one at a
// time, each with a memory read, then a compare, over the n bins of the action
// count in force; the result is then loaded into the output register.
// The bins are cleared when the result is loaded.
// cfg_wr_en/cfg_wr_data write the action count; write it only when idle.
// Reset clears all bins and sets the action count to 16.
// While the receiver stalls, the result is held in the output register and the
// next votes are still taken; a following last vote waits at the end of its scan
// until the held result has gone.
module weighted_action_vote_top
    import wav_pkg::*;
#(
    parameter int MAX_ACTIONS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACT_W-1:0]    vote_action,
    input  logic [WEIGHT_W-1:0] vote_weight,
    input  logic                last_vote,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ACT_W-1:0]    best_action
);

    localparam int NUM_BINS = (MAX_ACTIONS < ACT_LIMIT) ? MAX_ACTIONS : ACT_LIMIT;
    localparam logic [CNT_W-1:0] LIM_N = CNT_W'(NUM_BINS);

    wav_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    num_actions_reg;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic                last_reg, last_next;
    logic                keep_reg, keep_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [ACT_W-1:0]    idx_reg, idx_next;
    logic [ACT_W-1:0]    best_reg, best_next;
    logic [BIN_W-1:0]    best_w_reg, best_w_next;
    logic                out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]    best_action_reg, best_action_next;

    logic [CNT_W-1:0]    n_eff;
    logic                in_accept;
    logic                out_load;
    logic                scan_end;
    wav_mem_ctl_t        mem_ctl;
    logic [BIN_W-1:0]    rd_data;
    logic [BIN_W-1:0]    alu_a, alu_b;
    logic                alu_cin;
    logic [BIN_W:0]      alu_sum;
    logic [BIN_W-1:0]    sat_sum;
    logic                greater;

    // Effective action count, held between one and the number of bins.
    always_comb
    begin
        if (num_actions_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (num_actions_reg > LIM_N)
        begin
            n_eff = LIM_N;
        end
        else
        begin
            n_eff = num_actions_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign scan_end  = ({1'b0, idx_reg} == (n_reg - CNT_W'(1)));

    // Shared adder: saturating add in S_ADD, best minus bin in S_SCAN_CMP.
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{BIN_W{1'b0}}, alu_cin};
    assign sat_sum = alu_sum[BIN_W] ? '1 : alu_sum[BIN_W-1:0];
    assign greater = !alu_sum[BIN_W];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = last_reg ? S_SCAN_RD : S_IDLE;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = scan_end ? S_DONE : S_SCAN_RD;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs: memory port and adder operands.
    always_comb
    begin
        mem_ctl         = '0;
        mem_ctl.wr_data = sat_sum;
        alu_a           = '0;
        alu_b           = '0;
        alu_cin         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                mem_ctl.rd_en   = in_accept;
                mem_ctl.rd_addr = vote_action;
            end
            S_ADD:
            begin
                alu_a           = rd_data;
                alu_b           = {{(BIN_W - WEIGHT_W){1'b0}}, weight_reg};
                mem_ctl.wr_en   = keep_reg;
                mem_ctl.wr_addr = act_reg;
            end
            S_SCAN_RD:
            begin
                mem_ctl.rd_en   = 1'b1;
                mem_ctl.rd_addr = idx_reg;
            end
            S_SCAN_CMP:
            begin
                alu_a   = best_w_reg;
                alu_b   = ~rd_data;
                alu_cin = 1'b1;
            end
            S_DONE:
            begin
                mem_ctl.clr = out_load;
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        act_next         = act_reg;
        weight_next      = weight_reg;
        last_next        = last_reg;
        keep_next        = keep_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        best_next        = best_reg;
        best_w_next      = best_w_reg;
        best_action_next = best_action_reg;
        out_valid_next   = out_valid_reg;

        // Capture a vote with the count in force at that moment.
        if (in_accept)
        begin
            act_next    = vote_action;
            weight_next = vote_weight;
            last_next   = last_vote;
            keep_next   = ({1'b0, vote_action} < n_eff);
            n_next      = n_eff;
            idx_next    = '0;
            best_next   = '0;
            best_w_next = '0;
        end

        // Strictly greater total takes over, so ties keep the lower index.
        if (state_reg == S_SCAN_CMP)
        begin
            if (greater)
            begin
                best_next   = idx_reg;
                best_w_next = rd_data;
            end
            idx_next = idx_reg + ACT_W'(1);
        end

        // Output register: drops when taken, loads at the end of a scan.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            best_action_next = best_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_actions_reg <= NUM_ACTIONS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                num_actions_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        weight_reg      <= weight_next;
        last_reg        <= last_next;
        keep_reg        <= keep_next;
        n_reg           <= n_next;
        idx_reg         <= idx_next;
        best_reg        <= best_next;
        best_w_reg      <= best_w_next;
        best_action_reg <= best_action_next;
    end

    // Bin storage.
    wav_bin_mem #(
        .DEPTH (NUM_BINS)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign best_action = best_action_reg;

    // An accepted vote always moves on to its add step.
    a_accept_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_ADD))
        else $error("accepted vote did not reach the add step");

    // The scan never compares a bin beyond the count in force.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CMP) |-> ({1'b0, idx_reg} < n_reg))
        else $error("scan index beyond action count");

    // The latched count is never zero and never above the bin count while busy.
    a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((n_reg != '0) && (n_reg <= LIM_N)))
        else $error("latched action count out of range");

    // An overflowing add writes the saturated total.
    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && alu_sum[BIN_W]) |-> (mem_ctl.wr_data == '1))
        else $error("bin did not saturate on overflow");

    // A result is loaded only when the output register is free or being taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("held result overwritten");

endmodule
